>>> sv/mlq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the multilevel queue scheduler.
// No dependencies; every other file in sv/ imports this package.

package mlq_pkg;

    localparam int ITEM_BITS  = 32;
    localparam int LEVEL_BITS = 3;
    localparam int CFG_BITS   = 4;

    localparam logic [CFG_BITS-1:0] LEVEL_COUNT_RST = 4'd8;

    // operation codes
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    typedef struct packed {
        logic                  kind;
        logic [LEVEL_BITS-1:0] level;
        logic [ITEM_BITS-1:0]  item_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [LEVEL_BITS-1:0] found_level;
        logic [ITEM_BITS-1:0]  item_out;
        logic                  all_empty;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DONE
    } mlq_state_t;

endpackage

>>> sv/multilevel_queue_rotating_search.sv
`timescale 1ns / 1ps
// Top level of the multilevel queue scheduler: control FSM, per-level
// pointer tables and result path. Depends on mlq_pkg, mlq_item_ram,
// mlq_rot_search.
//
//  channel   | signals                      | handshake
//  ----------+------------------------------+-------------------------------
//  command   | start, busy, cmd             | taken when start && !busy
//  result    | done, result                 | one-cycle strobe, no backpressure
//  config    | cfg_valid, cfg_ready, cfg_data | written when valid && ready
//
// Each transaction has a lookup state (range check, full check, rotating
// search, pointer update, RAM access) and a result state in which the
// registered RAM read data is on the result port; the RAM's registered read
// is why the result state exists. busy is high only in the lookup state,
// so a new command is taken in the same cycle a result is shown, and no
// command is taken during a lookup. Reset clears the pointer tables and
// fill counts in flops at once; the item RAM needs no clearing pass.
// The receiver cannot stall: done is a strobe.

module multilevel_queue_rotating_search #(
    parameter int LEVELS = 8,
    parameter int DEPTH  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  mlq_pkg::in_item_t            cmd,
    output logic                         done,
    output mlq_pkg::out_item_t           result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mlq_pkg::CFG_BITS-1:0] cfg_data
);
    import mlq_pkg::*;

    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;  // level index
    localparam int NW    = $clog2(LEVELS + 1);                 // level count
    localparam int CW    = (NW > CFG_BITS) ? NW : CFG_BITS;    // compare width
    localparam int PW    = $clog2(DEPTH);                      // slot pointer
    localparam int FW    = $clog2(DEPTH + 1);                  // fill count
    localparam int WORDS = LEVELS * DEPTH;
    localparam int AW    = $clog2(WORDS);

    // ---------------------------------------------------------------
    // FSM
    // ---------------------------------------------------------------
    mlq_state_t state_reg, state_next;
    logic       accept;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                busy       = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = accept ? ST_LOOK : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Config register; only written while idle by contract
    // ---------------------------------------------------------------
    logic [CFG_BITS-1:0] level_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= LEVEL_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            level_count_reg <= cfg_data;
        end
    end

    // clamp: 0 acts as 1, above LEVELS acts as LEVELS
    logic [CW-1:0] lc_ext, n_act;

    always_comb
    begin
        lc_ext = CW'(level_count_reg);
        if (lc_ext == '0)
        begin
            n_act = CW'(1);
        end
        else if (lc_ext > CW'(LEVELS))
        begin
            n_act = CW'(LEVELS);
        end
        else
        begin
            n_act = lc_ext;
        end
    end

    // ---------------------------------------------------------------
    // Command capture
    // ---------------------------------------------------------------
    in_item_t op_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= cmd;
        end
    end

    // ---------------------------------------------------------------
    // Per-level pointer tables
    // ---------------------------------------------------------------
    logic [PW-1:0] head_reg [LEVELS];
    logic [PW-1:0] tail_reg [LEVELS];
    logic [FW-1:0] fill_reg [LEVELS];
    logic [LEVELS-1:0] nonempty;

    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            nonempty[l] = (fill_reg[l] != '0);
        end
    end

    // ---------------------------------------------------------------
    // Lookup cycle
    // ---------------------------------------------------------------
    logic [CW-1:0] lvl_ext;
    logic [LW-1:0] lvl_idx;
    logic          in_range;
    logic          hit;
    logic [LW-1:0] srch_lvl;

    assign lvl_ext  = CW'(op_reg.level);
    assign lvl_idx  = LW'(op_reg.level);
    assign in_range = (lvl_ext < n_act);

    mlq_rot_search #(
        .LEVELS (LEVELS),
        .LW     (LW),
        .CW     (CW)
    ) u_search (
        .nonempty  (nonempty),
        .start_lvl (lvl_ext),
        .n_act     (n_act),
        .hit       (hit),
        .found     (srch_lvl)
    );

    logic [1:0]     status_reg, status_next;
    logic [LW-1:0]  found_reg, found_next;
    logic           pop_reg, pop_next;
    logic           all_empty_reg, all_empty_next;
    logic           upd;          // table entry tgt changes this cycle
    logic [LW-1:0]  tgt;
    logic [PW-1:0]  ptr_sel, ptr_inc;
    logic           ram_en, ram_we;
    logic [AW-1:0]  ram_addr;
    logic [ITEM_BITS-1:0] ram_q;
    logic           ne_after;

    always_comb
    begin
        status_next = STAT_OK;
        found_next  = '0;
        pop_next    = 1'b0;
        upd         = 1'b0;
        tgt         = lvl_idx;
        if (!in_range)
        begin
            status_next = STAT_RANGE;
        end
        else if (op_reg.kind == KIND_ENQ)
        begin
            if (fill_reg[lvl_idx] >= FW'(DEPTH))
            begin
                status_next = STAT_FULL;
            end
            else
            begin
                upd = 1'b1;
            end
        end
        else
        begin
            tgt = srch_lvl;
            if (!hit)
            begin
                status_next = STAT_EMPTY;
            end
            else
            begin
                upd        = 1'b1;
                pop_next   = 1'b1;
                found_next = srch_lvl;
            end
        end

        ptr_sel  = (op_reg.kind == KIND_ENQ) ? tail_reg[tgt] : head_reg[tgt];
        ptr_inc  = (ptr_sel == PW'(DEPTH - 1)) ? '0 : ptr_sel + PW'(1);
        ram_en   = busy && upd;
        ram_we   = (op_reg.kind == KIND_ENQ);
        ram_addr = AW'(AW'(tgt) * AW'(DEPTH) + AW'(ptr_sel));

        // emptiness of active levels after this step
        all_empty_next = 1'b1;
        for (int l = 0; l < LEVELS; l++)
        begin
            ne_after = nonempty[l];
            if (upd && (LW'(l) == tgt))
            begin
                ne_after = (op_reg.kind == KIND_ENQ) ? 1'b1 : (fill_reg[l] != FW'(1));
            end
            if ((CW'(l) < n_act) && ne_after)
            begin
                all_empty_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                fill_reg[l] <= '0;
            end
        end
        else if (busy && upd)
        begin
            if (op_reg.kind == KIND_ENQ)
            begin
                tail_reg[tgt] <= ptr_inc;
                fill_reg[tgt] <= fill_reg[tgt] + FW'(1);
            end
            else
            begin
                head_reg[tgt] <= ptr_inc;
                fill_reg[tgt] <= fill_reg[tgt] - FW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            status_reg    <= status_next;
            found_reg     <= found_next;
            pop_reg       <= pop_next;
            all_empty_reg <= all_empty_next;
        end
    end

    // Only one RAM access per transaction, and busy blocks the next lookup
    // until the access has landed, so no forwarding is needed.
    mlq_item_ram #(
        .WORDS (WORDS)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (op_reg.item_data),
        .rdata (ram_q)
    );

    // ---------------------------------------------------------------
    // Result
    // ---------------------------------------------------------------
    assign result.status      = status_reg;
    assign result.found_level = LEVEL_BITS'(found_reg);
    assign result.item_out    = pop_reg ? ram_q : '0;
    assign result.all_empty   = all_empty_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted command did not enter lookup");

    a_look_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("lookup not followed by result strobe");

    a_done_after_look: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without lookup");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STAT_EMPTY) |-> result.all_empty)
        else $error("empty status while some active level holds items");

    a_no_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != STAT_OK && !pop_reg)
            |-> (result.found_level == '0 && result.item_out == '0))
        else $error("nonzero item fields without a pop");

endmodule

>>> sv/mlq_item_ram.sv
`timescale 1ns / 1ps
// Single-port item word memory with a registered read.
// Depends on mlq_pkg for the item width.

module mlq_item_ram #(
    parameter int WORDS = 128
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic                         we,
    input  logic [$clog2(WORDS)-1:0]     addr,
    input  logic [mlq_pkg::ITEM_BITS-1:0] wdata,
    output logic [mlq_pkg::ITEM_BITS-1:0] rdata
);
    import mlq_pkg::*;

    logic [ITEM_BITS-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && !we)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

>>> sv/mlq_rot_search.sv
`timescale 1ns / 1ps
// Rotating priority search: first non-empty level at or after the start
// level, wrapping at the active level count. Depends on mlq_pkg.

module mlq_rot_search #(
    parameter int LEVELS = 8,
    parameter int LW     = 3,
    parameter int CW     = 4
) (
    input  logic [LEVELS-1:0] nonempty,
    input  logic [CW-1:0]     start_lvl,
    input  logic [CW-1:0]     n_act,
    output logic              hit,
    output logic [LW-1:0]     found
);
    import mlq_pkg::*;

    logic [CW:0] cand;

    // walk from the far end down so the nearest hit wins
    always_comb
    begin
        hit   = 1'b0;
        found = '0;
        cand  = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            cand = {1'b0, start_lvl} + (CW+1)'(i);
            if (cand >= {1'b0, n_act})
            begin
                cand = cand - {1'b0, n_act};
            end
            if (((CW+1)'(i) < {1'b0, n_act}) && nonempty[cand[LW-1:0]])
            begin
                hit   = 1'b1;
                found = cand[LW-1:0];
            end
        end
    end

endmodule

>>> tb/sv/multilevel_queue_rotating_search_test.sv
`timescale 1ns / 1ps
// Self-checking bench for multilevel_queue_rotating_search: a directed table, then random
// phases at several level counts, checked against typed-in or behavioral-model results.
// Depends on mlq_pkg and the RTL in sv/.

module multilevel_queue_rotating_search_test;
    import mlq_pkg::*;

    localparam int Q_LEVELS      = 8;
    localparam int Q_DEPTH       = 16;
    localparam int MAX_GAP       = 17;
    localparam int SETTLE_CYCLES = 4;      // lookup and result states plus margin
    localparam int PHASES        = 11;
    localparam int PHASE_ITEMS   = 55;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SHOW_LIMIT    = 10;

    // One row of the directed table: either a command (repeated reps times, data
    // stepped by one per repeat) or a level_count write carried in data[3:0].
    typedef enum logic {
        ROW_CMD,
        ROW_CFG
    } row_op_e;

    typedef struct packed {
        row_op_e               op;
        logic                  kind;
        logic [LEVEL_BITS-1:0] level;
        logic [ITEM_BITS-1:0]  data;
        logic [4:0]            reps;
        logic                  known;  // 1: want is typed in, 0: use the model
        out_item_t             want;
    } plan_row_t;

    localparam out_item_t NO_WANT = '0;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  cmd;
    logic      done;
    out_item_t result;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_BITS-1:0] cfg_data;

    multilevel_queue_rotating_search #(
        .LEVELS (Q_LEVELS),
        .DEPTH  (Q_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Behavioral copy of the scheduler: per-level ring buffers and the register.
    logic [ITEM_BITS-1:0] shadow_items [Q_LEVELS][Q_DEPTH];
    logic [3:0]           shadow_head  [Q_LEVELS];
    logic [3:0]           shadow_tail  [Q_LEVELS];
    logic [4:0]           shadow_fill  [Q_LEVELS];
    logic [CFG_BITS-1:0]  shadow_count;

    out_item_t pending_results [$];   // expected results, oldest first
    int        mismatches = 0;
    int        cycles     = 0;
    bit        burst_mode = 0;        // phase with no sender gaps

    // Directed table. Rows with known=1 carry results that are plain at a glance;
    // the rest go through the model.
    plan_row_t directed_plan [20] = '{
        // nothing queued after reset
        '{ROW_CMD, KIND_DEQ, 3'd0, 32'h0000_0000, 5'd1,  1'b1,
          '{STAT_EMPTY, 3'd0, 32'd0, 1'b1}},
        '{ROW_CMD, KIND_ENQ, 3'd7, 32'hFFFF_FFFF, 5'd1,  1'b1,
          '{STAT_OK, 3'd0, 32'd0, 1'b0}},
        '{ROW_CMD, KIND_ENQ, 3'd0, 32'h0000_0000, 5'd1,  1'b1,
          '{STAT_OK, 3'd0, 32'd0, 1'b0}},
        // search from 1 finds level 7; search from 7 wraps to level 0
        '{ROW_CMD, KIND_DEQ, 3'd1, 32'h0000_0000, 5'd1,  1'b0, NO_WANT},
        '{ROW_CMD, KIND_DEQ, 3'd7, 32'h0000_0000, 5'd1,  1'b0, NO_WANT},
        // fill level 3, then one more is dropped
        '{ROW_CMD, KIND_ENQ, 3'd3, 32'h1234_5678, 5'd16, 1'b0, NO_WANT},
        '{ROW_CMD, KIND_ENQ, 3'd3, 32'hDEAD_BEEF, 5'd1,  1'b1,
          '{STAT_FULL, 3'd0, 32'd0, 1'b0}},
        // two levels: level 3 is hidden, so the queues look empty
        '{ROW_CFG, KIND_ENQ, 3'd0, 32'h0000_0002, 5'd1,  1'b0, NO_WANT},
        '{ROW_CMD, KIND_DEQ, 3'd0, 32'h0000_0000, 5'd1,  1'b1,
          '{STAT_EMPTY, 3'd0, 32'd0, 1'b1}},
        '{ROW_CMD, KIND_ENQ, 3'd2, 32'h5555_AAAA, 5'd1,  1'b1,
          '{STAT_RANGE, 3'd0, 32'd0, 1'b1}},
        '{ROW_CMD, KIND_DEQ, 3'd5, 32'h0000_0000, 5'd1,  1'b1,
          '{STAT_RANGE, 3'd0, 32'd0, 1'b1}},
        // zero count behaves as one level
        '{ROW_CFG, KIND_ENQ, 3'd0, 32'h0000_0000, 5'd1,  1'b0, NO_WANT},
        '{ROW_CMD, KIND_ENQ, 3'd1, 32'hAAAA_5555, 5'd1,  1'b1,
          '{STAT_RANGE, 3'd0, 32'd0, 1'b1}},
        '{ROW_CMD, KIND_ENQ, 3'd0, 32'h8000_0001, 5'd1,  1'b1,
          '{STAT_OK, 3'd0, 32'd0, 1'b0}},
        '{ROW_CMD, KIND_DEQ, 3'd0, 32'h0000_0000, 5'd1,  1'b1,
          '{STAT_OK, 3'd0, 32'h8000_0001, 1'b1}},
        // count above eight behaves as eight; level 3 comes back
        '{ROW_CFG, KIND_ENQ, 3'd0, 32'h0000_000F, 5'd1,  1'b0, NO_WANT},
        '{ROW_CMD, KIND_DEQ, 3'd6, 32'h0000_0000, 5'd1,  1'b0, NO_WANT},
        '{ROW_CMD, KIND_DEQ, 3'd4, 32'h0000_0000, 5'd15, 1'b0, NO_WANT},
        '{ROW_CMD, KIND_DEQ, 3'd4, 32'h0000_0000, 5'd1,  1'b1,
          '{STAT_EMPTY, 3'd0, 32'd0, 1'b1}},
        '{ROW_CFG, KIND_ENQ, 3'd0, 32'h0000_0008, 5'd1,  1'b0, NO_WANT}
    };

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Levels actually searched: zero acts as one, above eight acts as eight.
    function automatic int levels_in_use();
        if (shadow_count == 0)
            return 1;
        if (shadow_count > Q_LEVELS)
            return Q_LEVELS;
        return int'(shadow_count);
    endfunction

    // Applies one command to the shadow queues and returns the result it produces.
    function automatic out_item_t schedule_step(in_item_t c);
        out_item_t r;
        int        n;
        int        l;
        bit        hit;
        n   = levels_in_use();
        r   = '0;
        hit = 1'b0;
        if (int'(c.level) >= n)
            r.status = STAT_RANGE;
        else if (c.kind == KIND_ENQ)
        begin
            if (shadow_fill[c.level] >= Q_DEPTH)
                r.status = STAT_FULL;
            else
            begin
                shadow_items[c.level][shadow_tail[c.level]] = c.item_data;
                shadow_tail[c.level] = shadow_tail[c.level] + 4'd1;   // wraps at depth
                shadow_fill[c.level] = shadow_fill[c.level] + 5'd1;
            end
        end
        else
        begin
            // rotating search: start level first, wrap at the level count
            r.status = STAT_EMPTY;
            for (int i = 0; i < n && !hit; i++)
            begin
                l = (int'(c.level) + i) % n;
                if (shadow_fill[l] != 0)
                begin
                    r.item_out    = shadow_items[l][shadow_head[l]];
                    r.found_level = LEVEL_BITS'(l);
                    r.status      = STAT_OK;
                    shadow_head[l] = shadow_head[l] + 4'd1;
                    shadow_fill[l] = shadow_fill[l] - 5'd1;
                    hit = 1'b1;
                end
            end
        end
        // hidden levels above the count do not count toward all_empty
        r.all_empty = 1'b1;
        for (int k = 0; k < n; k++)
            if (shadow_fill[k] != 0)
                r.all_empty = 1'b0;
        return r;
    endfunction

    task automatic flag_mismatch(string what, out_item_t want, out_item_t got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
        begin
            $display("%s at cycle %0d: expected st=%0d lvl=%0d item=%h empty=%0b",
                     what, cycles, want.status, want.found_level, want.item_out,
                     want.all_empty);
            $display("    got st=%0d lvl=%0d item=%h empty=%0b",
                     got.status, got.found_level, got.item_out, got.all_empty);
        end
    endtask

    // Result checker: every strobe is one transaction, matched to the oldest expectation.
    always @(posedge clk)
    begin : check_result
        out_item_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("unexpected result", NO_WANT, result);
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status || result.found_level !== want.found_level
                    || result.item_out !== want.item_out
                    || result.all_empty !== want.all_empty)
                    flag_mismatch("mismatch", want, result);
            end
        end
    end

    // Presents one command after a random gap and waits for it to be taken.
    // start stays high across back-to-back transactions (gap of zero).
    task automatic issue(in_item_t c, bit known, out_item_t want);
        int        gap;
        out_item_t predicted;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // taken at this edge; the model advances even when the result is typed in
        predicted = schedule_step(c);
        pending_results.push_back(known ? want : predicted);
        @(negedge clk);
    endtask

    // Idle point: no command pending, every result back, pipeline settled.
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_level_count(logic [CFG_BITS-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_count = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random command: mostly levels in use, some above the count; data with
    // all-zero and all-one words mixed in.
    function automatic in_item_t random_item(int enq_pct);
        in_item_t c;
        int       n;
        n      = levels_in_use();
        c.kind = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
        if ($urandom_range(0, 9) == 0)
            c.level = LEVEL_BITS'($urandom_range(0, Q_LEVELS - 1));
        else
            c.level = LEVEL_BITS'($urandom_range(0, n - 1));
        case ($urandom_range(0, 7))
            0:       c.item_data = '0;
            1:       c.item_data = '1;
            default: c.item_data = $urandom;
        endcase
        return c;
    endfunction

    initial
    begin : stimulus
        in_item_t            c;
        plan_row_t           row;
        int                  enq_pct;
        logic [CFG_BITS-1:0] count;

        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        for (int l = 0; l < Q_LEVELS; l++)
        begin
            shadow_head[l] = '0;
            shadow_tail[l] = '0;
            shadow_fill[l] = '0;
        end
        shadow_count = LEVEL_COUNT_RST;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        foreach (directed_plan[r])
        begin
            row = directed_plan[r];
            if (row.op == ROW_CFG)
                write_level_count(row.data[CFG_BITS-1:0]);
            else
                for (int k = 0; k < int'(row.reps); k++)
                begin
                    c.kind      = row.kind;
                    c.level     = row.level;
                    c.item_data = row.data + ITEM_BITS'(k);
                    issue(c, row.known, row.want);
                end
        end

        // random phases: the extremes of the count first, then random counts.
        // Enqueue share varies so that levels both fill up and drain dry.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       count = 4'd8;
                1:       count = 4'd1;
                2:       count = 4'd15;
                3:       count = 4'd0;
                4:       count = 4'd3;
                default: count = CFG_BITS'($urandom_range(0, 15));
            endcase
            write_level_count(count);
            case ($urandom_range(0, 2))
                0:       enq_pct = 30;
                1:       enq_pct = 55;
                default: enq_pct = 80;
            endcase
            burst_mode = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                issue(random_item(enq_pct), 1'b0, NO_WANT);
            burst_mode = 1'b0;
        end

        drain();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
